// File: sv/qltl_pkg.sv
// shared types, codes and helpers of the quoted list token lexer
`default_nettype none

package qltl_pkg;

    localparam int NEST_DEPTH_DEF = 16;
    localparam int INDEX_BITS_DEF = 16;

    // scanner modes
    typedef enum logic [3:0] {
        MODE_READY,
        MODE_STR,
        MODE_ESC,
        MODE_VAL,
        MODE_VALD,
        MODE_DOT,
        MODE_IDENT,
        MODE_QUOTE,
        MODE_DONE,
        MODE_ERR
    } t_mode;

    // result kinds
    localparam logic [2:0] KIND_BEGIN = 3'd0;
    localparam logic [2:0] KIND_BYTE  = 3'd1;
    localparam logic [2:0] KIND_END   = 3'd2;
    localparam logic [2:0] KIND_LIST  = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;
    localparam logic [2:0] KIND_ERROR = 3'd5;

    // token types
    localparam logic [2:0] TYPE_STRING = 3'd0;
    localparam logic [2:0] TYPE_VALUE  = 3'd1;
    localparam logic [2:0] TYPE_OPEN   = 3'd2;
    localparam logic [2:0] TYPE_CLOSE  = 3'd3;
    localparam logic [2:0] TYPE_QLIST  = 3'd4;

    // error codes
    localparam logic [2:0] ERR_UNTERM    = 3'd0;
    localparam logic [2:0] ERR_BAD_VALUE = 3'd1;
    localparam logic [2:0] ERR_BAD_LIST  = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
    localparam logic [2:0] ERR_CAPACITY  = 3'd4;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  token_type;
        logic [15:0] token_index;
        logic [7:0]  data_byte;
        logic [15:0] list_length;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

    // all results caused by one input item
    typedef struct packed {
        logic [1:0]       num;
        t_result [2:0]    res;
    } t_bundle;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z))
            || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z))
            || (c == CH_UNDER);
    endfunction

    function automatic t_result mk_result(input logic [2:0] kind, input logic [2:0] ttype,
                                          input logic [15:0] idx, input logic [7:0] data,
                                          input logic [15:0] len, input logic [2:0] err);
        t_result r;
        r.kind        = kind;
        r.token_type  = ttype;
        r.token_index = idx;
        r.data_byte   = data;
        r.list_length = len;
        r.error_code  = err;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic t_bundle add_result(input t_bundle b, input t_result r);
        t_bundle o;
        o = b;
        if (b.num != 2'd3) begin
            o.res[b.num] = r;
            o.num        = b.num + 2'd1;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// File: sv/qltl_if.sv
// item channels of the quoted list token lexer
`default_nettype none

interface qltl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink (input valid, input ch, input start_req, output ready);
endinterface

interface qltl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  token_type;
    logic [15:0] token_index;
    logic [7:0]  data_byte;
    logic [15:0] list_length;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output token_type, output token_index,
                    output data_byte, output list_length, output error_code,
                    output last, input ready);
    modport sink (input valid, input kind, input token_type, input token_index,
                  input data_byte, input list_length, input error_code,
                  input last, output ready);
endinterface

`default_nettype wire

// File: sv/quoted_list_token_lexer_core.sv
// top level of the quoted list token lexer
`default_nettype none

// Streaming lexer for NUL-terminated text, one byte per input item. The
// scanner decides each byte in the cycle it is accepted, so a new byte can
// enter every cycle; each byte yields zero to three result items, which go
// out one per ready cycle through a two-bundle queue. The input is held off only
// while that queue is full, so the sustained rate is one byte per cycle as
// long as bytes average at most one result, and otherwise one result per
// cycle sets the pace. The innermost open quoted list lives in registers and
// the lists below it in a NEST_DEPTH-entry memory with a registered read: on
// every cycle the entry under the next top is read ahead, with forwarding when
// a push writes that same entry, so back-to-back closing parens pop without a
// stall. The memory has no clearing pass; only pushed entries are read.
// start_req on an item clears mode, token counter and stack depth before that
// byte is lexed. After done or an error every byte is swallowed until start_req.
module quoted_list_token_lexer_core #(
    parameter int NEST_DEPTH = qltl_pkg::NEST_DEPTH_DEF,
    parameter int INDEX_BITS = qltl_pkg::INDEX_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    qltl_in_if.sink      i_in,
    qltl_out_if.source   o_out
);

    localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    // byte handshake: ready whenever the bundle queue has room
    logic                    w_ready;
    logic                    w_fire;

    // stack memory ports
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic [2*INDEX_BITS-1:0] w_wr_data;
    logic [AW-1:0]           w_rd_addr;
    logic [2*INDEX_BITS-1:0] w_below;

    // results of the accepted byte
    qltl_pkg::t_bundle       w_bundle;
    logic                    w_bundle_valid;

    assign i_in.ready = w_ready;
    assign w_fire     = i_in.valid && w_ready;

    qltl_lex #(
        .NEST_DEPTH (NEST_DEPTH),
        .INDEX_BITS (INDEX_BITS)
    ) u_lex (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_ch           (i_in.ch),
        .i_start        (i_in.start_req),
        .i_below        (w_below),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_data      (w_wr_data),
        .o_rd_addr      (w_rd_addr),
        .o_bundle       (w_bundle),
        .o_bundle_valid (w_bundle_valid)
    );

    qltl_stack #(
        .NEST_DEPTH (NEST_DEPTH),
        .INDEX_BITS (INDEX_BITS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_below)
    );

    qltl_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bundle (w_bundle),
        .i_push   (w_bundle_valid),
        .o_ready  (w_ready),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// File: sv/qltl_stack.sv
// list stack body memory with registered read and write-to-read forwarding
`default_nettype none

module qltl_stack #(
    parameter int NEST_DEPTH = qltl_pkg::NEST_DEPTH_DEF,
    parameter int INDEX_BITS = qltl_pkg::INDEX_BITS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_wr_en,
    input  wire logic [(NEST_DEPTH > 1 ? $clog2(NEST_DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [2*INDEX_BITS-1:0]                     i_wr_data,
    input  wire logic [(NEST_DEPTH > 1 ? $clog2(NEST_DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [2*INDEX_BITS-1:0]                     o_rd_data
);

    localparam int EW = 2 * INDEX_BITS;

    logic [EW-1:0] r_mem [NEST_DEPTH];
    logic [EW-1:0] r_rd_data;
    logic [EW-1:0] r_fwd_data;
    logic          r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_fwd_data <= i_wr_data;
    end

    // same-entry write and read in one cycle: take the written word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

`default_nettype wire

// File: sv/qltl_lex.sv
// per-byte scanner: mode, token counter, top of list stack, result bundle
`default_nettype none

module qltl_lex #(
    parameter int NEST_DEPTH = qltl_pkg::NEST_DEPTH_DEF,
    parameter int INDEX_BITS = qltl_pkg::INDEX_BITS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_fire,
    input  wire logic [7:0]                                  i_ch,
    input  wire logic                                        i_start,
    input  wire logic [2*INDEX_BITS-1:0]                     i_below,
    output logic                                             o_wr_en,
    output logic      [(NEST_DEPTH > 1 ? $clog2(NEST_DEPTH) : 1)-1:0] o_wr_addr,
    output logic      [2*INDEX_BITS-1:0]                     o_wr_data,
    output logic      [(NEST_DEPTH > 1 ? $clog2(NEST_DEPTH) : 1)-1:0] o_rd_addr,
    output qltl_pkg::t_bundle                                o_bundle,
    output logic                                             o_bundle_valid
);

    localparam int AW  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int DW0 = $clog2(NEST_DEPTH + 1);
    localparam int DW  = (DW0 < 2) ? 2 : DW0;
    localparam int WW  = (INDEX_BITS > 16) ? INDEX_BITS : 16;
    localparam logic [INDEX_BITS-1:0] CMAX = '1;

    qltl_pkg::t_mode          r_mode;
    logic [INDEX_BITS-1:0]    r_counter;
    logic [DW-1:0]            r_depth;
    logic [INDEX_BITS-1:0]    r_top_idx;
    logic [INDEX_BITS-1:0]    r_top_cnt;

    qltl_pkg::t_mode          c_mode;
    logic [INDEX_BITS-1:0]    c_cnt;
    logic [DW-1:0]            c_depth;
    logic [DW-1:0]            c_dm1;
    logic [INDEX_BITS-1:0]    c_top_idx;
    logic [INDEX_BITS-1:0]    c_top_cnt;
    logic                     c_fresh;
    logic                     c_wr_en;
    logic [AW-1:0]            c_wr_addr;
    logic [2*INDEX_BITS-1:0]  c_wr_data;
    qltl_pkg::t_bundle        c_b;
    logic [DW-1:0]            c_nd;
    logic [DW-1:0]            c_nd2;

    function automatic logic [15:0] to16(input logic [INDEX_BITS-1:0] v);
        logic [WW-1:0] w;
        w = WW'(v);
        return w[15:0];
    endfunction

    // count one element into the innermost open list, saturating
    function automatic logic [INDEX_BITS-1:0] bump(input logic [DW-1:0] depth,
                                                   input logic [INDEX_BITS-1:0] cnt);
        logic [INDEX_BITS-1:0] o;
        o = cnt;
        if ((depth != '0) && (cnt != CMAX)) begin
            o = cnt + 1'b1;
        end
        return o;
    endfunction

    function automatic qltl_pkg::t_result byte_res(input logic [7:0] c);
        return qltl_pkg::mk_result(qltl_pkg::KIND_BYTE, qltl_pkg::TYPE_STRING, 16'd0, c,
                                   16'd0, qltl_pkg::ERR_UNTERM);
    endfunction

    function automatic qltl_pkg::t_result err_res(input logic [2:0] code);
        return qltl_pkg::mk_result(qltl_pkg::KIND_ERROR, qltl_pkg::TYPE_STRING, 16'd0, 8'd0,
                                   16'd0, code);
    endfunction

    always_comb begin
        c_mode    = i_start ? qltl_pkg::MODE_READY : r_mode;
        c_cnt     = i_start ? '0 : r_counter;
        c_depth   = i_start ? '0 : r_depth;
        c_dm1     = '0;
        c_top_idx = r_top_idx;
        c_top_cnt = r_top_cnt;
        c_fresh   = 1'b0;
        c_wr_en   = 1'b0;
        c_wr_addr = '0;
        c_wr_data = {r_top_idx, r_top_cnt};
        c_b       = '0;

        case (c_mode)
            qltl_pkg::MODE_STR: begin
                if (i_ch == qltl_pkg::CH_NUL) begin
                    c_b    = qltl_pkg::add_result(c_b, err_res(qltl_pkg::ERR_UNTERM));
                    c_mode = qltl_pkg::MODE_ERR;
                end else if (i_ch == qltl_pkg::CH_DQUOTE) begin
                    c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_END,
                        qltl_pkg::TYPE_STRING, to16(INDEX_BITS'(c_cnt - 1'b1)), 8'd0, 16'd0,
                        qltl_pkg::ERR_UNTERM));
                    c_mode = qltl_pkg::MODE_READY;
                end else begin
                    c_b = qltl_pkg::add_result(c_b, byte_res(i_ch));
                    if (i_ch == qltl_pkg::CH_BSLASH) begin
                        c_mode = qltl_pkg::MODE_ESC;
                    end
                end
            end
            qltl_pkg::MODE_ESC: begin
                if (i_ch == qltl_pkg::CH_NUL) begin
                    c_b    = qltl_pkg::add_result(c_b, err_res(qltl_pkg::ERR_UNTERM));
                    c_mode = qltl_pkg::MODE_ERR;
                end else begin
                    c_b    = qltl_pkg::add_result(c_b, byte_res(i_ch));
                    c_mode = qltl_pkg::MODE_STR;
                end
            end
            qltl_pkg::MODE_VAL, qltl_pkg::MODE_VALD: begin
                if (qltl_pkg::is_digit(i_ch)) begin
                    c_b = qltl_pkg::add_result(c_b, byte_res(i_ch));
                end else if ((i_ch == qltl_pkg::CH_DOT) && (c_mode == qltl_pkg::MODE_VAL)) begin
                    c_b    = qltl_pkg::add_result(c_b, byte_res(i_ch));
                    c_mode = qltl_pkg::MODE_VALD;
                end else begin
                    c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_END,
                        qltl_pkg::TYPE_VALUE, to16(INDEX_BITS'(c_cnt - 1'b1)), 8'd0, 16'd0,
                        qltl_pkg::ERR_UNTERM));
                    c_mode  = qltl_pkg::MODE_READY;
                    c_fresh = 1'b1;
                end
            end
            qltl_pkg::MODE_DOT: begin
                if (qltl_pkg::is_digit(i_ch)) begin
                    c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_BEGIN,
                        qltl_pkg::TYPE_VALUE, to16(c_cnt), 8'd0, 16'd0, qltl_pkg::ERR_UNTERM));
                    c_cnt     = c_cnt + 1'b1;
                    c_top_cnt = bump(c_depth, c_top_cnt);
                    c_b       = qltl_pkg::add_result(c_b, byte_res(qltl_pkg::CH_DOT));
                    c_b       = qltl_pkg::add_result(c_b, byte_res(i_ch));
                    c_mode    = qltl_pkg::MODE_VALD;
                end else begin
                    c_b    = qltl_pkg::add_result(c_b, err_res(qltl_pkg::ERR_BAD_VALUE));
                    c_mode = qltl_pkg::MODE_ERR;
                end
            end
            qltl_pkg::MODE_IDENT: begin
                if (qltl_pkg::is_letter(i_ch)) begin
                    c_b = qltl_pkg::add_result(c_b, byte_res(i_ch));
                end else begin
                    c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_END,
                        qltl_pkg::TYPE_VALUE, to16(INDEX_BITS'(c_cnt - 1'b1)), 8'd0, 16'd0,
                        qltl_pkg::ERR_UNTERM));
                    c_mode  = qltl_pkg::MODE_READY;
                    c_fresh = 1'b1;
                end
            end
            qltl_pkg::MODE_QUOTE: begin
                if (i_ch != qltl_pkg::CH_OPEN) begin
                    c_b    = qltl_pkg::add_result(c_b, err_res(qltl_pkg::ERR_BAD_LIST));
                    c_mode = qltl_pkg::MODE_ERR;
                end else if (c_depth >= DW'(NEST_DEPTH)) begin
                    c_b    = qltl_pkg::add_result(c_b, err_res(qltl_pkg::ERR_CAPACITY));
                    c_mode = qltl_pkg::MODE_ERR;
                end else begin
                    // push: old top goes to the memory, new list lives in the top registers
                    c_top_cnt = bump(c_depth, c_top_cnt);
                    if (c_depth != '0) begin
                        c_dm1     = c_depth - DW'(1);
                        c_wr_en   = 1'b1;
                        c_wr_addr = c_dm1[AW-1:0];
                        c_wr_data = {c_top_idx, c_top_cnt};
                    end
                    c_top_idx = c_cnt;
                    c_top_cnt = '0;
                    c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_BEGIN,
                        qltl_pkg::TYPE_QLIST, to16(c_cnt), 8'd0, 16'd0, qltl_pkg::ERR_UNTERM));
                    c_cnt   = c_cnt + 1'b1;
                    c_depth = c_depth + DW'(1);
                    c_mode  = qltl_pkg::MODE_READY;
                end
            end
            qltl_pkg::MODE_DONE, qltl_pkg::MODE_ERR: begin
                c_mode = c_mode;
            end
            default: begin
                c_fresh = 1'b1;
            end
        endcase

        // byte outside any token, also the byte that ended a value
        if (c_fresh) begin
            if (i_ch == qltl_pkg::CH_NUL) begin
                if (c_depth != '0) begin
                    c_b    = qltl_pkg::add_result(c_b, err_res(qltl_pkg::ERR_BAD_LIST));
                    c_mode = qltl_pkg::MODE_ERR;
                end else begin
                    c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_DONE,
                        qltl_pkg::TYPE_STRING, 16'd0, 8'd0, 16'd0, qltl_pkg::ERR_UNTERM));
                    c_mode = qltl_pkg::MODE_DONE;
                end
            end else if (i_ch == qltl_pkg::CH_DQUOTE) begin
                c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_BEGIN,
                    qltl_pkg::TYPE_STRING, to16(c_cnt), 8'd0, 16'd0, qltl_pkg::ERR_UNTERM));
                c_cnt     = c_cnt + 1'b1;
                c_top_cnt = bump(c_depth, c_top_cnt);
                c_mode    = qltl_pkg::MODE_STR;
            end else if (qltl_pkg::is_digit(i_ch)) begin
                c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_BEGIN,
                    qltl_pkg::TYPE_VALUE, to16(c_cnt), 8'd0, 16'd0, qltl_pkg::ERR_UNTERM));
                c_cnt     = c_cnt + 1'b1;
                c_top_cnt = bump(c_depth, c_top_cnt);
                c_b       = qltl_pkg::add_result(c_b, byte_res(i_ch));
                c_mode    = qltl_pkg::MODE_VAL;
            end else if (i_ch == qltl_pkg::CH_DOT) begin
                c_mode = qltl_pkg::MODE_DOT;
            end else if (i_ch == qltl_pkg::CH_OPEN) begin
                c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_BEGIN,
                    qltl_pkg::TYPE_OPEN, to16(c_cnt), 8'd0, 16'd0, qltl_pkg::ERR_UNTERM));
                c_cnt = c_cnt + 1'b1;
            end else if (i_ch == qltl_pkg::CH_CLOSE) begin
                if (c_depth != '0) begin
                    // pop: report the top, entry below comes from the prefetched read
                    c_depth = c_depth - DW'(1);
                    c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_LIST,
                        qltl_pkg::TYPE_QLIST, to16(c_top_idx), 8'd0, to16(c_top_cnt),
                        qltl_pkg::ERR_UNTERM));
                    c_top_idx = i_below[2*INDEX_BITS-1:INDEX_BITS];
                    c_top_cnt = i_below[INDEX_BITS-1:0];
                end else begin
                    c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_BEGIN,
                        qltl_pkg::TYPE_CLOSE, to16(c_cnt), 8'd0, 16'd0, qltl_pkg::ERR_UNTERM));
                    c_cnt = c_cnt + 1'b1;
                end
            end else if (i_ch == qltl_pkg::CH_SQUOTE) begin
                c_mode = qltl_pkg::MODE_QUOTE;
            end else if (qltl_pkg::is_letter(i_ch)) begin
                if (c_depth != '0) begin
                    c_b    = qltl_pkg::add_result(c_b, err_res(qltl_pkg::ERR_BAD_LIST));
                    c_mode = qltl_pkg::MODE_ERR;
                end else begin
                    c_b = qltl_pkg::add_result(c_b, qltl_pkg::mk_result(qltl_pkg::KIND_BEGIN,
                        qltl_pkg::TYPE_VALUE, to16(c_cnt), 8'd0, 16'd0, qltl_pkg::ERR_UNTERM));
                    c_cnt  = c_cnt + 1'b1;
                    c_b    = qltl_pkg::add_result(c_b, byte_res(i_ch));
                    c_mode = qltl_pkg::MODE_IDENT;
                end
            end else if ((i_ch != qltl_pkg::CH_SPACE) && (i_ch != qltl_pkg::CH_NL)) begin
                c_b    = qltl_pkg::add_result(c_b, err_res(qltl_pkg::ERR_UNKNOWN));
                c_mode = qltl_pkg::MODE_ERR;
            end
        end

        if (c_b.num != 2'd0) begin
            c_b.res[c_b.num - 2'd1].last = 1'b1;
        end
    end

    // read the entry that sits below the top after this cycle
    always_comb begin
        c_nd      = i_fire ? c_depth : r_depth;
        c_nd2     = c_nd - DW'(2);
        o_rd_addr = (c_nd >= DW'(2)) ? c_nd2[AW-1:0] : '0;
    end

    assign o_wr_en        = i_fire && c_wr_en;
    assign o_wr_addr      = c_wr_addr;
    assign o_wr_data      = c_wr_data;
    assign o_bundle       = c_b;
    assign o_bundle_valid = i_fire && (c_b.num != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= qltl_pkg::MODE_READY;
            r_counter <= '0;
            r_depth   <= '0;
        end else if (i_fire) begin
            r_mode    <= c_mode;
            r_counter <= c_cnt;
            r_depth   <= c_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_top_idx <= c_top_idx;
            r_top_cnt <= c_top_cnt;
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(NEST_DEPTH))
        else $error("list stack depth beyond nest limit");

    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_mode == qltl_pkg::MODE_DONE || r_mode == qltl_pkg::MODE_ERR)
         && !(i_fire && i_start)) |=> (r_mode == $past(r_mode)))
        else $error("done or error state left without start");

    a_spill_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |=> (r_depth == DW'($past(r_depth) + 1'b1)))
        else $error("stack memory written without a push");

endmodule

`default_nettype wire

// File: sv/qltl_outq.sv
// bundle queue and result serializer on the output channel
`default_nettype none

module qltl_outq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire qltl_pkg::t_bundle   i_bundle,
    input  wire logic                i_push,
    output logic                     o_ready,
    qltl_out_if.source               o_out
);

    localparam int QD = 2;
    localparam int PW = $clog2(QD);
    localparam int CW = $clog2(QD + 1);

    qltl_pkg::t_bundle r_q [QD];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [CW-1:0]     r_cnt;
    logic [1:0]        r_pos;

    qltl_pkg::t_bundle c_head;
    qltl_pkg::t_result c_res;
    logic              c_out_fire;
    logic              c_pop;

    assign c_head     = r_q[r_rd];
    assign c_res      = c_head.res[r_pos];
    assign c_out_fire = o_out.valid && o_out.ready;
    assign c_pop      = c_out_fire && (r_pos == (c_head.num - 2'd1));
    assign o_ready    = (r_cnt != CW'(QD));

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.kind        = c_res.kind;
    assign o_out.token_type  = c_res.token_type;
    assign o_out.token_index = c_res.token_index;
    assign o_out.data_byte   = c_res.data_byte;
    assign o_out.list_length = c_res.list_length;
    assign o_out.error_code  = c_res.error_code;
    assign o_out.last        = c_res.last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_pos <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (c_pop) begin
                r_rd  <= r_rd + 1'b1;
                r_pos <= '0;
            end else if (c_out_fire) begin
                r_pos <= r_pos + 2'd1;
            end
            case ({i_push, c_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> ((c_head.num != 2'd0) && (r_pos < c_head.num)))
        else $error("serializer position outside head bundle");

endmodule

`default_nettype wire
